// File: src/anlp_pkg.sv
package anlp_pkg;

    localparam int CHAR_W = 8;
    localparam int ACC_W  = 36;
    localparam int VAL_W  = 37;
    localparam int CNT_W  = 7;
    localparam int MODE_W = 3;

    typedef enum logic [1:0] {
        FMT_DEC  = 2'd0,
        FMT_HEX  = 2'd1,
        FMT_BIN  = 2'd2,
        FMT_NONE = 2'd3
    } t_format;

    // width mode register codes
    localparam logic [MODE_W-1:0] MODE_RAW16  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAW32  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UINT8  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UINT16 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INT16  = 3'd4;

    localparam logic [ACC_W-1:0] LIMIT_16     = 36'h0_0000_FFFF;
    localparam logic [ACC_W-1:0] LIMIT_32     = 36'h0_FFFF_FFFF;
    localparam logic [ACC_W-1:0] UINT8_MAX    = 36'h0_0000_00FF;
    localparam logic [ACC_W-1:0] UINT16_MAX   = 36'h0_0000_FFFF;
    localparam logic [ACC_W-1:0] INT16_MAX    = 36'h0_0000_7FFF;
    localparam logic [ACC_W-1:0] INT16_MINMAG = 36'h0_0000_8000;

    localparam logic [CNT_W-1:0] CNT_MAX        = 7'd127;
    localparam logic [CNT_W-1:0] DEC_MAX_DIGITS = 7'd19;
    localparam logic [CNT_W-1:0] BIN_MAX_DIGITS = 7'd64;
    localparam logic [CNT_W-1:0] HEX_MAX_DIGITS = 7'd8;
    // odd hex length only counts while the digit count is at most eight
    localparam logic [CNT_W-1:0] HEX_ODD_MAX_P  = 7'd10;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_bin(input logic [CHAR_W-1:0] c);
        return (c == CH_0) || (c == CH_1);
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (is_dec(c)) begin
            t = c - CH_0;
            return {1'b1, t[3:0]};
        end else if ((c >= CH_UA) && (c <= CH_UF)) begin
            t = c - CH_UA + 8'd10;
            return {1'b1, t[3:0]};
        end else if ((c >= CH_LA) && (c <= CH_LF)) begin
            t = c - CH_LA + 8'd10;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic t_format pick_format(input logic [CHAR_W-1:0] a,
                                            input logic [CHAR_W-1:0] b);
        if (a == CH_0) begin
            return (b == CH_X) ? FMT_HEX : FMT_NONE;
        end else if (a == CH_B) begin
            return is_bin(b) ? FMT_BIN : FMT_NONE;
        end else if (a == CH_MINUS) begin
            return is_dec(b) ? FMT_DEC : FMT_NONE;
        end
        return is_dec(a) ? FMT_DEC : FMT_NONE;
    endfunction

    function automatic logic [ACC_W-1:0] times_ten(input logic [ACC_W-1:0] x);
        return {x[ACC_W-4:0], 3'b000} + {x[ACC_W-2:0], 1'b0};
    endfunction

endpackage

// File: src/anlp_char_if.sv
interface anlp_char_if import anlp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// File: src/anlp_result_if.sv
interface anlp_result_if import anlp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    t_format                 format;
    logic                    error;

    modport source (output valid, output value, output format, output error, input ready);
    modport sink   (input valid, input value, input format, input error, output ready);
endinterface

// File: src/ascii_number_literal_parser.sv
// ascii integer literal parser (decimal, 0x hex, b binary)
// i_char: one character per beat, last set on the final character of a literal.
// o_result: one beat per literal, sent for the beat that carried last:
//   value (37-bit two's complement), format (dec/hex/bin/none), error.
// i_cfg_we/i_cfg_wdata: width mode register (raw16, raw32, uint8, uint16, int16);
//   write it only while no literal is in flight.
// stages: a character is captured in the input register; from there it updates
//   the per-literal state and, on last, loads the result register, which drives o_result.
// throughput: one character per cycle except while a last character waits (see stall), set by
//   the single accumulate step (shift or multiply-by-ten add) between the input and state registers.
// stall: while the result register holds an untaken beat, non-last characters
//   keep flowing; a last character waits in the input register, and the input
//   side stops only then.
// reset: synchronous active low, clears the mode to raw16, the per-literal
//   state and both valid flags.
module ascii_number_literal_parser import anlp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [MODE_W-1:0]  i_cfg_wdata,
    anlp_char_if.sink          i_char,
    anlp_result_if.source      o_result
);

    // config
    logic [MODE_W-1:0] r_mode;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    // per-literal state
    logic [ACC_W-1:0]  r_acc,   n_acc;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CHAR_W-1:0] r_first, n_first;
    t_format           r_fmt,   n_fmt;
    logic              r_neg,   n_neg;
    logic              r_stop,  n_stop;
    logic              r_err,   n_err;
    logic [3:0]        r_nib,   n_nib;

    // result register
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value, n_out_value;
    t_format                 r_out_format, n_out_format;
    logic                    r_out_error, n_out_error;

    logic             advance;
    logic [CNT_W-1:0] p, p_m1, p_m2, dec_d;
    logic [ACC_W-1:0] limit;
    logic [3:0]       dig, first_dig;
    logic [4:0]       hx;
    t_format          fmt_p;
    logic [ACC_W-1:0] fin_acc, mag;
    logic             fin_err, mag_neg, res_err;

    // stage moves on unless a last beat finds the result register busy
    assign advance = r_in_valid && (!r_last || !r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || advance;

    assign o_result.valid  = r_out_valid;
    assign o_result.value  = r_out_value;
    assign o_result.format = r_out_format;
    assign o_result.error  = r_out_error;

    // position of this character in the literal, saturating
    assign p     = (r_count == CNT_MAX) ? r_count : r_count + 7'd1;
    assign p_m1  = p - 7'd1;
    assign p_m2  = p - 7'd2;
    assign dec_d = r_neg ? p_m1 : p;
    assign limit = (r_mode == MODE_RAW32) ? LIMIT_32 : LIMIT_16;

    always_comb begin
        logic [CHAR_W-1:0] t0, t1;
        t0        = r_char - CH_0;
        t1        = r_first - CH_0;
        dig       = t0[3:0];
        first_dig = t1[3:0];
        hx        = hex_nibble(r_char);
        fmt_p     = pick_format(r_first, r_char);
    end

    // per-character state update
    always_comb begin
        n_acc   = r_acc;
        n_count = p;
        n_first = r_first;
        n_fmt   = r_fmt;
        n_neg   = r_neg;
        n_stop  = r_stop;
        n_err   = r_err;
        n_nib   = r_nib;
        priority if (p == 7'd1) begin
            n_first = r_char;
        end else if (p == 7'd2) begin
            // format decided; decimal may take both characters at once
            n_fmt = fmt_p;
            if (fmt_p == FMT_DEC) begin
                n_neg = (r_first == CH_MINUS);
                if (r_first == CH_MINUS) begin
                    n_acc = ACC_W'(dig);
                end else if (is_dec(r_char)) begin
                    n_acc = times_ten(ACC_W'(first_dig)) + ACC_W'(dig);
                end else begin
                    n_acc  = ACC_W'(first_dig);
                    n_err  = 1'b1;
                    n_stop = 1'b1;
                end
            end else if (fmt_p == FMT_BIN) begin
                n_acc = ACC_W'(r_char[0]);
            end
        end else begin
            unique case (r_fmt)
                FMT_DEC: begin
                    if (!r_stop && (dec_d <= DEC_MAX_DIGITS)) begin
                        if (r_acc > limit) begin
                            n_stop = 1'b1;
                        end else if (is_dec(r_char)) begin
                            n_acc = times_ten(r_acc) + ACC_W'(dig);
                        end else begin
                            n_err  = 1'b1;
                            n_stop = 1'b1;
                        end
                    end
                end
                FMT_BIN: begin
                    if (!r_stop && (p_m1 <= BIN_MAX_DIGITS)) begin
                        if (r_acc > limit) begin
                            n_stop = 1'b1;
                        end else if (is_bin(r_char)) begin
                            n_acc = {r_acc[ACC_W-2:0], r_char[0]};
                        end else begin
                            n_err  = 1'b1;
                            n_stop = 1'b1;
                        end
                    end
                end
                FMT_HEX: begin
                    if (!r_stop && (p_m2 >= 7'd1) && (p_m2 <= HEX_MAX_DIGITS)) begin
                        if (!hx[4]) begin
                            n_err  = 1'b1;
                            n_stop = 1'b1;
                        end else if (p_m2[0]) begin
                            n_nib = hx[3:0];
                        end else begin
                            n_acc = {r_acc[ACC_W-9:0], r_nib, hx[3:0]};
                        end
                    end
                end
                FMT_NONE: begin
                end
            endcase
        end
    end

    // result for a last character
    always_comb begin
        n_out_format = n_fmt;
        fin_acc      = n_acc;
        fin_err      = n_err;
        if (p == 7'd1) begin
            // single character: only a digit is numeric
            n_out_format = is_dec(r_char) ? FMT_DEC : FMT_NONE;
            fin_acc      = is_dec(r_char) ? ACC_W'(dig) : n_acc;
        end
        mag     = fin_acc;
        res_err = fin_err;
        mag_neg = 1'b0;
        unique case (n_out_format)
            FMT_NONE: begin
                mag     = '0;
                res_err = 1'b1;
            end
            FMT_HEX: begin
                if (p[0] && (p <= HEX_ODD_MAX_P)) begin
                    mag     = '0;
                    res_err = 1'b1;
                end
            end
            FMT_DEC: begin
                mag_neg = n_neg && !fin_err && (mag != '0);
            end
            FMT_BIN: begin
            end
        endcase
        if (n_out_format != FMT_NONE) begin
            unique case (r_mode)
                MODE_UINT8:  if (mag_neg || (mag > UINT8_MAX)) res_err = 1'b1;
                MODE_UINT16: if (mag_neg || (mag > UINT16_MAX)) res_err = 1'b1;
                MODE_INT16: begin
                    if (mag_neg ? (mag > INT16_MINMAG) : (mag > INT16_MAX)) begin
                        res_err = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out_value = mag_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        n_out_error = res_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RAW16;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_char <= i_char.character;
            r_last <= i_char.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_last)) begin
            r_acc   <= '0;
            r_count <= '0;
            r_first <= '0;
            r_fmt   <= FMT_DEC;
            r_neg   <= 1'b0;
            r_stop  <= 1'b0;
            r_err   <= 1'b0;
            r_nib   <= '0;
        end else if (advance) begin
            r_acc   <= n_acc;
            r_count <= n_count;
            r_first <= n_first;
            r_fmt   <= n_fmt;
            r_neg   <= n_neg;
            r_stop  <= n_stop;
            r_err   <= n_err;
            r_nib   <= n_nib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out_value  <= n_out_value;
            r_out_format <= n_out_format;
            r_out_error  <= n_out_error;
        end
    end

    // literal state starts clean after a last character
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> (r_count == '0) && (r_acc == '0) && !r_stop && !r_err)
        else $error("literal state not cleared after last beat");

    // a waiting last character stays put while the result is held
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_last && r_out_valid && !o_result.ready
        |=> r_in_valid && r_last)
        else $error("last beat dropped while result stalled");

    // non-numeric literals give zero with error
    a_none_is_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_format == FMT_NONE)
        |-> r_out_error && (r_out_value == '0))
        else $error("non-numeric result without error or with value");

    // only decimal results are negative
    a_neg_is_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_value[VAL_W-1] |-> (r_out_format == FMT_DEC))
        else $error("negative value on non-decimal result");

    // hex keeps at most four digit pairs
    a_hex_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fmt == FMT_HEX) |-> (r_acc[ACC_W-1:32] == '0))
        else $error("hex accumulator beyond 32 bits");

endmodule

// File: tb/sv/tb_ascii_number_literal_parser.sv
`timescale 1ns / 100ps

module tb_ascii_number_literal_parser;
    import anlp_pkg::*;

    // one character beat as queued for the driver
    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } t_char_beat;

    // one parsed literal as the block should report it
    typedef struct {
        logic signed [36:0] value;
        t_format            fmt;
        logic               err;
    } t_lit_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MODE_W-1:0] i_cfg_wdata;

    anlp_char_if   u_char_if ();
    anlp_result_if u_res_if ();

    ascii_number_literal_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (u_char_if),
        .o_result    (u_res_if)
    );

    // character beats waiting to be offered, literals expected back
    t_char_beat  char_q[$];
    t_lit_result want_q[$];
    t_char_beat  next_beat;

    // idle odds per side in percent, long hold-off of the result side
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    logic        hold_req;
    logic [9:0]  hold_left;

    int unsigned miss_cnt;
    int unsigned items_queued;

    // parser state as predicted on this side
    logic [MODE_W-1:0] mode_q;
    bit [35:0]         lit_acc;
    int unsigned       lit_pos;     // saturates at 127
    byte unsigned      lit_lead;
    t_format           lit_fmt;
    bit                lit_neg;
    bit                lit_halt;    // no further digits taken
    bit                lit_bad;
    bit [3:0]          lit_hi;      // first hex digit of a pair

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------
    function automatic bit is_digit(byte unsigned c);
        return (c >= "0") && (c <= "9");
    endfunction

    // decimal and binary stop once the value passes this bound
    function automatic bit [35:0] acc_limit();
        return (mode_q == MODE_RAW32) ? 36'hFFFF_FFFF : 36'hFFFF;
    endfunction

    function automatic void take_dec(byte unsigned c, int unsigned d);
        if (lit_halt || d > 19) return;
        if (lit_acc > acc_limit()) begin
            lit_halt = 1'b1;
            return;
        end
        if (is_digit(c)) begin
            lit_acc = lit_acc * 36'd10 + 36'(c - 8'h30);
        end else begin
            lit_bad  = 1'b1;
            lit_halt = 1'b1;
        end
    endfunction

    function automatic void take_bin(byte unsigned c, int unsigned d);
        if (lit_halt || d > 64) return;
        if (lit_acc > acc_limit()) begin
            lit_halt = 1'b1;
            return;
        end
        if (c == "0" || c == "1") begin
            lit_acc = {lit_acc[34:0], c[0]};
        end else begin
            lit_bad  = 1'b1;
            lit_halt = 1'b1;
        end
    endfunction

    // advance the literal by one accepted character; on the final one the
    // expected result goes to want_q and the literal state clears
    function automatic void parse_char(byte unsigned c, bit lst);
        int unsigned d;
        bit [3:0]    nib;
        bit          nib_ok;
        bit [35:0]   mag;
        bit          sign;
        bit          e;
        t_lit_result r;

        if (lit_pos < 127) lit_pos++;

        if (lit_pos == 1) begin
            lit_lead = c;
        end else if (lit_pos == 2) begin
            // the first two characters pick the format
            if (lit_lead == "0") begin
                lit_fmt = (c == "x") ? FMT_HEX : FMT_NONE;
            end else if (lit_lead == "b") begin
                lit_fmt = (c == "0" || c == "1") ? FMT_BIN : FMT_NONE;
            end else if (lit_lead == "-") begin
                lit_fmt = is_digit(c) ? FMT_DEC : FMT_NONE;
            end else begin
                lit_fmt = is_digit(lit_lead) ? FMT_DEC : FMT_NONE;
            end
            if (lit_fmt == FMT_DEC) begin
                lit_neg = (lit_lead == "-");
                if (lit_neg) begin
                    take_dec(c, 1);
                end else begin
                    take_dec(lit_lead, 1);
                    take_dec(c, 2);
                end
            end else if (lit_fmt == FMT_BIN) begin
                take_bin(c, 1);
            end
        end else begin
            case (lit_fmt)
                FMT_DEC: take_dec(c, lit_neg ? lit_pos - 1 : lit_pos);
                FMT_BIN: take_bin(c, lit_pos - 1);
                FMT_HEX: begin
                    d = lit_pos - 2;
                    if (!lit_halt && d <= 8) begin
                        nib_ok = 1'b1;
                        nib    = '0;
                        if (is_digit(c)) nib = 4'(c - 8'h30);
                        else if (c >= "A" && c <= "F") nib = 4'(c - 8'h41 + 8'd10);
                        else if (c >= "a" && c <= "f") nib = 4'(c - 8'h61 + 8'd10);
                        else nib_ok = 1'b0;
                        if (!nib_ok) begin
                            lit_bad  = 1'b1;
                            lit_halt = 1'b1;
                        end else if (d[0]) begin
                            lit_hi = nib;
                        end else begin
                            lit_acc = {lit_acc[27:0], lit_hi, nib};
                        end
                    end
                end
                default: ;
            endcase
        end

        if (!lst) return;

        // a literal of one character is decimal only if it is a digit
        if (lit_pos == 1) begin
            lit_fmt = is_digit(lit_lead) ? FMT_DEC : FMT_NONE;
            if (lit_fmt == FMT_DEC) take_dec(lit_lead, 1);
        end

        mag  = lit_acc;
        e    = lit_bad;
        sign = 1'b0;
        case (lit_fmt)
            FMT_NONE: begin
                mag = '0;
                e   = 1'b1;
            end
            FMT_HEX: begin
                // odd digit count, counting at most eight
                d = (lit_pos - 2 > 8) ? 8 : lit_pos - 2;
                if (d[0]) begin
                    mag = '0;
                    e   = 1'b1;
                end
            end
            FMT_DEC: sign = lit_neg && !lit_bad && (mag != 0);
            default: ;
        endcase

        // range modes flag the error but keep the full value
        if (lit_fmt != FMT_NONE) begin
            case (mode_q)
                MODE_UINT8:  if (sign || mag > 36'hFF) e = 1'b1;
                MODE_UINT16: if (sign || mag > 36'hFFFF) e = 1'b1;
                MODE_INT16:  if (sign ? mag > 36'd32768 : mag > 36'd32767) e = 1'b1;
                default: ;
            endcase
        end

        r.value = sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        r.fmt   = lit_fmt;
        r.err   = e;
        want_q.push_back(r);

        lit_acc  = '0;
        lit_pos  = 0;
        lit_lead = '0;
        lit_fmt  = FMT_DEC;
        lit_neg  = 1'b0;
        lit_halt = 1'b0;
        lit_bad  = 1'b0;
        lit_hi   = '0;
    endfunction

    // ---------------------------------------------------------------
    // driver: offers queued beats, feeds every accepted beat to the
    // predictor
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            u_char_if.valid <= 1'b0;
        end else if (!u_char_if.valid || u_char_if.ready) begin
            if (u_char_if.valid) parse_char(u_char_if.character, u_char_if.last);
            if (char_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_beat = char_q.pop_front();
                u_char_if.valid     <= 1'b1;
                u_char_if.character <= next_beat.ch;
                u_char_if.last      <= next_beat.lst;
            end else begin
                u_char_if.valid <= 1'b0;
            end
        end
    end

    // long hold-off of the result side, counted apart from the monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= '0;
        end else if (hold_req) begin
            hold_left <= 10'd300;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1'b1;
        end
    end

    task automatic report_miss(string msg);
        miss_cnt++;
        if (miss_cnt <= 10) $display("mismatch: %s", msg);
    endtask

    // ---------------------------------------------------------------
    // monitor: each accepted result beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lit_result want;
        if (!i_rst_n) begin
            u_res_if.ready <= 1'b0;
        end else begin
            if (u_res_if.valid && u_res_if.ready) begin
                if (want_q.size() == 0) begin
                    report_miss($sformatf(
                        "result beat with none pending: value %0d format %0d error %0b",
                        u_res_if.value, u_res_if.format, u_res_if.error));
                end else begin
                    want = want_q.pop_front();
                    if (u_res_if.value !== want.value)
                        report_miss($sformatf("value got %0d expected %0d",
                                              u_res_if.value, want.value));
                    if (u_res_if.format !== want.fmt)
                        report_miss($sformatf("format got %0d expected %0d",
                                              u_res_if.format, want.fmt));
                    if (u_res_if.error !== want.err)
                        report_miss($sformatf("error got %0b expected %0b",
                                              u_res_if.error, want.err));
                end
            end
            u_res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic push_lit(byte unsigned b[$]);
        foreach (b[i]) char_q.push_back('{ch: b[i], lst: (i == b.size() - 1)});
        items_queued += b.size();
    endtask

    task automatic push_text(string s);
        byte unsigned b[$];
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        push_lit(b);
    endtask

    // one random literal; mostly well formed with random content, the rest
    // noise or broken by a stray character
    task automatic gen_literal();
        byte unsigned b[$];
        int unsigned  kind;
        int unsigned  n;
        longint       v;
        string        s;
        string        hex_chars;
        longint       bound_vals[14];

        hex_chars  = "0123456789abcdefABCDEF";
        bound_vals = '{0, 255, 256, 65535, 65536, 32767, 32768, -32768, -32769,
                       64'd4294967295, 64'd4294967296, -1, -65535, 99999};
        kind = $urandom_range(99);
        if (kind < 28) begin
            // decimal, sometimes long enough to pass the limit or 19 digits
            if ($urandom_range(3) == 0) b.push_back("-");
            n = ($urandom_range(4) == 0) ? $urandom_range(7, 22) : $urandom_range(1, 6);
            repeat (n) b.push_back(8'h30 + 8'($urandom_range(9)));
        end else if (kind < 48) begin
            // hex, odd counts and more than eight digits included
            b.push_back("0");
            b.push_back("x");
            n = $urandom_range(11);
            repeat (n) b.push_back(hex_chars[$urandom_range(21)]);
        end else if (kind < 66) begin
            b.push_back("b");
            n = ($urandom_range(4) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 20);
            repeat (n) b.push_back(8'h30 + 8'($urandom_range(1)));
        end else if (kind < 80) begin
            // decimal values around the range-mode and limit boundaries
            v = bound_vals[$urandom_range(13)];
            s = (v == 0 && $urandom_range(1) != 0) ? "-0" : $sformatf("%0d", v);
            for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
        end else begin
            // noise: any byte, often after a lead that starts a format
            n = $urandom_range(1, 4);
            case ($urandom_range(3))
                0: b.push_back("0");
                1: b.push_back("b");
                2: b.push_back("-");
                default: b.push_back(8'($urandom_range(255)));
            endcase
            repeat (n - 1) b.push_back(8'($urandom_range(255)));
        end
        // stray character inside an otherwise good literal
        if (kind < 66 && b.size() > 2 && $urandom_range(9) == 0)
            b[$urandom_range(2, b.size() - 1)] = 8'($urandom_range(255));
        push_lit(b);
    endtask

    // block is idle: nothing to send, nothing in flight, nothing expected
    task automatic wait_idle();
        while (char_q.size() != 0 || u_char_if.valid || want_q.size() != 0)
            @(posedge i_clk);
        // allow for the two-stage pipeline behind the last result
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = m;
    endtask

    initial begin
        logic [MODE_W-1:0] phase_mode[6];
        byte unsigned      long_lit[$];
        int unsigned       start_items;

        phase_mode = '{MODE_RAW16, MODE_RAW32, MODE_UINT8,
                       MODE_UINT16, MODE_INT16, MODE_RAW32};

        // every input known from time zero
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = MODE_RAW16;
        u_char_if.valid     = 1'b0;
        u_char_if.character = '0;
        u_char_if.last      = 1'b0;
        u_res_if.ready      = 1'b0;
        hold_req            = 1'b0;
        send_gap_pct        = 18;
        recv_gap_pct        = 86;
        miss_cnt            = 0;
        items_queued        = 0;

        mode_q   = MODE_RAW16;
        lit_acc  = '0;
        lit_pos  = 0;
        lit_lead = '0;
        lit_fmt  = FMT_DEC;
        lit_neg  = 1'b0;
        lit_halt = 1'b0;
        lit_bad  = 1'b0;
        lit_hi   = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_RAW16);

        // directed: bare 0x, single digit, lone minus and b, short negative,
        // odd hex, mixed-case hex pair, shortest binary, leading zero,
        // bad decimal digit, bad hex pair
        push_text("0x");
        push_text("7");
        push_text("-");
        push_text("b");
        push_text("-5");
        push_text("0x1");
        push_text("0xfF");
        push_text("b1");
        push_text("05");
        push_text("1z");
        push_text("0xg0");
        push_text("9");

        // random phases; each ends idle before the mode changes, which also
        // makes the sender wait for every pending result
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_mode(phase_mode[p]);
            if (p < 2) begin
                send_gap_pct = 18;
                recv_gap_pct = 86;
            end else if (p < 4) begin
                send_gap_pct = 86;
                recv_gap_pct = 18;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            start_items = items_queued;
            while (items_queued - start_items < 80) gen_literal();
            if (p == 4) begin
                // result side holds off while the sender keeps going, so
                // a pending last beat backs up the input
                @(posedge i_clk);
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            if (p == 5) begin
                // longer than the saturating character counter
                long_lit.delete();
                repeat (130) long_lit.push_back(8'h30 + 8'($urandom_range(9)));
                push_lit(long_lit);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (miss_cnt == 0 && want_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
src/anlp_pkg.sv
src/anlp_char_if.sv
src/anlp_result_if.sv
src/ascii_number_literal_parser.sv
tb/sv/tb_ascii_number_literal_parser.sv
